FILE: design/assert_macros.svh
// assertion macros shared by the scancode converter modules
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define ASSERT_HOLDS(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion failed");

// expression must never be true outside reset
`define ASSERT_NEVER(label, clk, rst, expr) \
   `ASSERT_HOLDS(label, clk, rst, !(expr))

`endif

FILE: design/skc_pkg.sv
// types, scancode constants and key maps for the scancode converter
// no dependencies
package skc_pkg;

   localparam int SCAN_W       = 8;
   localparam int TARGET_W     = 3;
   localparam int AMOUNT_W     = 35;
   localparam int STEP_W       = 32;
   localparam int BUTTON_W     = 33;
   localparam int CSR_DATA_W   = 33;
   localparam int CSR_INDEX_W  = 1;
   localparam int KEY_W        = 8;
   localparam int MAP_LEN      = 58;
   localparam int MAP_IDX_W    = 6;

   localparam int QUEUE_DEPTH  = 2;
   localparam int RESULT_DEPTH = 2;

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_POINTER_STEP = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_BUTTON_DOWN  = 1'd1;

   localparam logic [STEP_W-1:0]   STEP_RESET   = 32'h0300_0000;
   localparam logic [BUTTON_W-1:0] BUTTON_RESET = 33'h1_0000_0000;

   // result targets
   localparam logic [TARGET_W-1:0] TARGET_KEY     = 3'd0;
   localparam logic [TARGET_W-1:0] TARGET_X       = 3'd1;
   localparam logic [TARGET_W-1:0] TARGET_Y       = 3'd2;
   localparam logic [TARGET_W-1:0] TARGET_BUTTON0 = 3'd3;
   localparam logic [TARGET_W-1:0] TARGET_BUTTON1 = 3'd4;
   localparam logic [TARGET_W-1:0] TARGET_BUTTON2 = 3'd5;

   // scancodes
   localparam logic [SCAN_W-1:0] SCAN_PREFIX    = 8'hE0;
   localparam logic [SCAN_W-1:0] SCAN_UP        = 8'h48;
   localparam logic [SCAN_W-1:0] SCAN_LEFT      = 8'h4B;
   localparam logic [SCAN_W-1:0] SCAN_DOWN      = 8'h50;
   localparam logic [SCAN_W-1:0] SCAN_RIGHT     = 8'h4D;
   localparam logic [SCAN_W-1:0] SCAN_KP7       = 8'h47;
   localparam logic [SCAN_W-1:0] SCAN_KP9       = 8'h49;
   localparam logic [SCAN_W-1:0] SCAN_KP5       = 8'h4C;
   localparam logic [SCAN_W-1:0] SCAN_KP7_UP    = 8'hC7;
   localparam logic [SCAN_W-1:0] SCAN_KP9_UP    = 8'hC9;
   localparam logic [SCAN_W-1:0] SCAN_KP5_UP    = 8'hCC;
   localparam logic [SCAN_W-1:0] SCAN_PGUP      = 8'h49;
   localparam logic [SCAN_W-1:0] SCAN_PGDN      = 8'h51;
   localparam logic [SCAN_W-1:0] SCAN_DELETE    = 8'h53;
   localparam logic [SCAN_W-1:0] SCAN_LSHIFT    = 8'h2A;
   localparam logic [SCAN_W-1:0] SCAN_RSHIFT    = 8'h36;
   localparam logic [SCAN_W-1:0] SCAN_LSHIFT_UP = 8'hAA;
   localparam logic [SCAN_W-1:0] SCAN_RSHIFT_UP = 8'hB6;
   localparam logic [SCAN_W-1:0] SCAN_CTRL      = 8'h1D;
   localparam logic [SCAN_W-1:0] SCAN_CTRL_UP   = 8'h9D;
   localparam logic [SCAN_W-1:0] SCAN_CAPS      = 8'h3A;

   // console key codes
   localparam logic [KEY_W-1:0] KEY_UP          = 8'd14;
   localparam logic [KEY_W-1:0] KEY_UP_SHIFT    = 8'd18;
   localparam logic [KEY_W-1:0] KEY_LEFT        = 8'd15;
   localparam logic [KEY_W-1:0] KEY_LEFT_SHIFT  = 8'd19;
   localparam logic [KEY_W-1:0] KEY_LEFT_CTRL   = 8'd4;
   localparam logic [KEY_W-1:0] KEY_DOWN        = 8'd16;
   localparam logic [KEY_W-1:0] KEY_DOWN_SHIFT  = 8'd20;
   localparam logic [KEY_W-1:0] KEY_RIGHT       = 8'd17;
   localparam logic [KEY_W-1:0] KEY_RIGHT_SHIFT = 8'd21;
   localparam logic [KEY_W-1:0] KEY_RIGHT_CTRL  = 8'd7;
   localparam logic [KEY_W-1:0] KEY_PGUP        = 8'd9;
   localparam logic [KEY_W-1:0] KEY_PGDN        = 8'd10;
   localparam logic [KEY_W-1:0] KEY_DELETE      = 8'd29;
   localparam logic [KEY_W-1:0] KEY_LINEFEED    = 8'd10;
   localparam logic [KEY_W-1:0] KEY_ENTER       = 8'd13;
   localparam logic [KEY_W-1:0] KEY_CTRL_V      = 8'd22;
   localparam logic [KEY_W-1:0] KEY_CTRL_X      = 8'd23;
   localparam logic [KEY_W-1:0] KEY_CTRL_C      = 8'd25;
   localparam logic [KEY_W-1:0] CASE_OFFSET     = 8'd32;

   localparam logic [KEY_W-1:0] MAP_PLAIN [MAP_LEN] = '{
      8'h00, 8'h1B, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36,
      8'h37, 8'h38, 8'h39, 8'h30, 8'h2D, 8'h3D, 8'h08, 8'h09,
      8'h71, 8'h77, 8'h65, 8'h72, 8'h74, 8'h79, 8'h75, 8'h69,
      8'h6F, 8'h70, 8'h5B, 8'h5D, 8'h0A, 8'h00, 8'h61, 8'h73,
      8'h64, 8'h66, 8'h67, 8'h68, 8'h6A, 8'h6B, 8'h6C, 8'h3B,
      8'h27, 8'h60, 8'h00, 8'h5C, 8'h7A, 8'h78, 8'h63, 8'h76,
      8'h62, 8'h6E, 8'h6D, 8'h2C, 8'h2E, 8'h2F, 8'h00, 8'h00,
      8'h00, 8'h20
   };

   localparam logic [KEY_W-1:0] MAP_SHIFTED [MAP_LEN] = '{
      8'h00, 8'h1B, 8'h21, 8'h40, 8'h23, 8'h24, 8'h25, 8'h5E,
      8'h26, 8'h2A, 8'h28, 8'h29, 8'h5F, 8'h2B, 8'h08, 8'h09,
      8'h51, 8'h57, 8'h45, 8'h52, 8'h54, 8'h59, 8'h55, 8'h49,
      8'h4F, 8'h50, 8'h7B, 8'h7D, 8'h0A, 8'h00, 8'h41, 8'h53,
      8'h44, 8'h46, 8'h47, 8'h48, 8'h4A, 8'h4B, 8'h4C, 8'h3A,
      8'h22, 8'h7E, 8'h00, 8'h7C, 8'h5A, 8'h58, 8'h43, 8'h56,
      8'h42, 8'h4E, 8'h4D, 8'h3C, 8'h3E, 8'h3F, 8'h00, 8'h00,
      8'h00, 8'h20
   };

   typedef enum logic [2:0] {
      KIND_KEY      = 3'd0,
      KIND_STEP_NEG = 3'd1,
      KIND_STEP_POS = 3'd2,
      KIND_PRESS    = 3'd3,
      KIND_RELEASE  = 3'd4
   } kind_type;

   // decoded work handed from front to back
   typedef struct packed {
      kind_type              kind;
      logic [TARGET_W-1:0]   target;
      logic [KEY_W-1:0]      key_code;
   } op_type;

   typedef struct packed {
      logic [TARGET_W-1:0]   target;
      logic [AMOUNT_W-1:0]   amount;
      logic                  pointer_takeover;
   } rsp_type;

   function automatic logic [KEY_W-1:0] key_map(input logic shift,
                                                input logic [MAP_IDX_W-1:0] idx);
      logic [KEY_W-1:0] code;
      code = '0;
      if (int'(idx) < MAP_LEN) begin
         code = shift ? MAP_SHIFTED[idx] : MAP_PLAIN[idx];
      end
      return code;
   endfunction

endpackage

FILE: design/skc_queue.sv
// small register queue used between stages of the scancode converter
// depends on skc_pkg and assert_macros.svh
`include "assert_macros.svh"

module skc_queue
   import skc_pkg::*;
#(
   parameter int WIDTH = $bits(op_type),
   parameter int DEPTH = QUEUE_DEPTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] wr_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] rd_data,
   output logic             empty
);

   localparam int PTR_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int COUNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0]   mem_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic               do_push, do_pop;

   assign full    = (count_ff == COUNT_W'(DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign rd_data = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= wr_data;
      end
   end

   `ASSERT_NEVER(a_count_bound, clock, reset, count_ff > COUNT_W'(DEPTH))
   `ASSERT_HOLDS(a_count_grows, clock, reset, (do_push && !do_pop) |=> count_ff > $past(count_ff))

endmodule

FILE: design/skc_front.sv
// front end: takes scancode words, keeps modifier flags, decodes work for the back end
// depends on skc_pkg and assert_macros.svh
`include "assert_macros.svh"

module skc_front
   import skc_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              accept,
   input  logic [SCAN_W-1:0] scan_byte,
   output logic              op_valid,
   output op_type            op
);

   logic shift_ff, shift_in;
   logic ctrl_ff, ctrl_in;
   logic caps_ff, caps_in;
   logic prefix_ff, prefix_in;
   logic [KEY_W-1:0] map_char;
   logic [KEY_W-1:0] case_char;

   assign map_char = key_map(shift_ff, scan_byte[MAP_IDX_W-1:0]);

   // caps swaps letter case
   always_comb begin
      case_char = map_char;
      if (caps_ff) begin
         if (map_char >= 8'h61 && map_char <= 8'h7A) begin
            case_char = map_char - CASE_OFFSET;
         end else if (map_char >= 8'h41 && map_char <= 8'h5A) begin
            case_char = map_char + CASE_OFFSET;
         end
      end
   end

   always_comb begin
      shift_in    = shift_ff;
      ctrl_in     = ctrl_ff;
      caps_in     = caps_ff;
      prefix_in   = prefix_ff;
      op_valid    = 1'b0;
      op.kind     = KIND_KEY;
      op.target   = TARGET_KEY;
      op.key_code = '0;
      if (scan_byte == SCAN_PREFIX) begin
         prefix_in = 1'b1;
      end else if (prefix_ff) begin
         prefix_in = 1'b0;
         case (scan_byte)
            SCAN_UP: begin
               op_valid    = 1'b1;
               op.key_code = shift_ff ? KEY_UP_SHIFT : KEY_UP;
            end
            SCAN_LEFT: begin
               op_valid    = 1'b1;
               op.key_code = shift_ff ? KEY_LEFT_SHIFT :
                             (ctrl_ff ? KEY_LEFT_CTRL : KEY_LEFT);
            end
            SCAN_DOWN: begin
               op_valid    = 1'b1;
               op.key_code = shift_ff ? KEY_DOWN_SHIFT : KEY_DOWN;
            end
            SCAN_RIGHT: begin
               op_valid    = 1'b1;
               op.key_code = shift_ff ? KEY_RIGHT_SHIFT :
                             (ctrl_ff ? KEY_RIGHT_CTRL : KEY_RIGHT);
            end
            SCAN_PGUP: begin
               op_valid    = 1'b1;
               op.key_code = KEY_PGUP;
            end
            SCAN_PGDN: begin
               op_valid    = 1'b1;
               op.key_code = KEY_PGDN;
            end
            SCAN_DELETE: begin
               op_valid    = 1'b1;
               op.key_code = KEY_DELETE;
            end
            SCAN_CTRL, SCAN_CTRL_UP: begin
               ctrl_in = !ctrl_ff;
            end
            default: begin
            end
         endcase
      end else begin
         case (scan_byte)
            SCAN_LEFT: begin
               op_valid  = 1'b1;
               op.kind   = KIND_STEP_NEG;
               op.target = TARGET_X;
            end
            SCAN_RIGHT: begin
               op_valid  = 1'b1;
               op.kind   = KIND_STEP_POS;
               op.target = TARGET_X;
            end
            SCAN_UP: begin
               op_valid  = 1'b1;
               op.kind   = KIND_STEP_NEG;
               op.target = TARGET_Y;
            end
            SCAN_DOWN: begin
               op_valid  = 1'b1;
               op.kind   = KIND_STEP_POS;
               op.target = TARGET_Y;
            end
            SCAN_KP7: begin
               op_valid  = 1'b1;
               op.kind   = KIND_PRESS;
               op.target = TARGET_BUTTON0;
            end
            SCAN_KP7_UP: begin
               op_valid  = 1'b1;
               op.kind   = KIND_RELEASE;
               op.target = TARGET_BUTTON0;
            end
            SCAN_KP9: begin
               op_valid  = 1'b1;
               op.kind   = KIND_PRESS;
               op.target = TARGET_BUTTON1;
            end
            SCAN_KP9_UP: begin
               op_valid  = 1'b1;
               op.kind   = KIND_RELEASE;
               op.target = TARGET_BUTTON1;
            end
            SCAN_KP5: begin
               op_valid  = 1'b1;
               op.kind   = KIND_PRESS;
               op.target = TARGET_BUTTON2;
            end
            SCAN_KP5_UP: begin
               op_valid  = 1'b1;
               op.kind   = KIND_RELEASE;
               op.target = TARGET_BUTTON2;
            end
            SCAN_LSHIFT, SCAN_RSHIFT, SCAN_LSHIFT_UP, SCAN_RSHIFT_UP: begin
               shift_in = !shift_ff;
            end
            SCAN_CTRL, SCAN_CTRL_UP: begin
               ctrl_in = !ctrl_ff;
            end
            SCAN_CAPS: begin
               caps_in = !caps_ff;
            end
            default: begin
               if (int'(scan_byte) < MAP_LEN) begin
                  op_valid    = 1'b1;
                  op.key_code = (case_char == KEY_LINEFEED) ? KEY_ENTER : case_char;
                  if (ctrl_ff) begin
                     if (case_char == 8'h76 || case_char == 8'h56) begin
                        op.key_code = KEY_CTRL_V;
                     end else if (case_char == 8'h78 || case_char == 8'h58) begin
                        op.key_code = KEY_CTRL_X;
                     end else if (case_char == 8'h63 || case_char == 8'h43) begin
                        op.key_code = KEY_CTRL_C;
                     end else if (case_char == 8'h64 || case_char == 8'h44) begin
                        op_valid = 1'b0;
                     end
                  end
               end
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         shift_ff  <= 1'b0;
         ctrl_ff   <= 1'b0;
         caps_ff   <= 1'b0;
         prefix_ff <= 1'b0;
      end else if (accept) begin
         shift_ff  <= shift_in;
         ctrl_ff   <= ctrl_in;
         caps_ff   <= caps_in;
         prefix_ff <= prefix_in;
      end
   end

   `ASSERT_HOLDS(a_prefix_sets, clock, reset, (accept && scan_byte == SCAN_PREFIX) |=> prefix_ff)
   `ASSERT_NEVER(a_prefix_silent, clock, reset, scan_byte == SCAN_PREFIX && op_valid)

endmodule

FILE: design/skc_back.sv
// back end: holds the pointer and button registers, turns decoded work into result words
// depends on skc_pkg
module skc_back
   import skc_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata,
   input  op_type                 op,
   output rsp_type                rsp
);

   logic [STEP_W-1:0]   step_ff;
   logic [BUTTON_W-1:0] button_ff;
   logic [AMOUNT_W-1:0] step_ext;

   assign step_ext = {{(AMOUNT_W - STEP_W){1'b0}}, step_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff   <= STEP_RESET;
         button_ff <= BUTTON_RESET;
      end else if (csr_we) begin
         if (csr_index == CSR_POINTER_STEP) begin
            step_ff <= csr_wdata[STEP_W-1:0];
         end
         if (csr_index == CSR_BUTTON_DOWN) begin
            button_ff <= csr_wdata[BUTTON_W-1:0];
         end
      end
   end

   always_comb begin
      rsp.target           = op.target;
      rsp.pointer_takeover = (op.kind != KIND_KEY);
      case (op.kind)
         KIND_KEY:      rsp.amount = {{(AMOUNT_W - KEY_W){1'b0}}, op.key_code};
         KIND_STEP_NEG: rsp.amount = '0 - step_ext;
         KIND_STEP_POS: rsp.amount = step_ext;
         KIND_PRESS:    rsp.amount = {{(AMOUNT_W - BUTTON_W){1'b0}}, button_ff};
         KIND_RELEASE:  rsp.amount = '0;
         default:       rsp.amount = '0;
      endcase
   end

endmodule

FILE: design/scancode_to_key_event.sv
// top level of the scancode set 1 to console key event converter
// depends on skc_pkg, skc_queue, skc_front and skc_back
//
//  channel   ports                                   moves
//  request   req_push, req_full, req_scan_byte       one scancode word
//  response  rsp_pop, rsp_empty, rsp_target,         one key, pointer or button word
//            rsp_amount, rsp_pointer_takeover
//  csr       csr_we, csr_index, csr_wdata            one register write
//
// one scancode word per cycle unless req_full; results pass the op queue, then the rsp queue
// front decodes in its accept cycle, back resolves one op per cycle unless rsp queue is full
// req_full rises only when the op queue is full because the response queue stays unpopped
// synchronous reset clears modifier flags, queues, and loads register defaults
module scancode_to_key_event
   import skc_pkg::*;
#(
   parameter int OP_DEPTH  = QUEUE_DEPTH,
   parameter int RSP_DEPTH = RESULT_DEPTH
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_push,
   input  logic [SCAN_W-1:0]          req_scan_byte,
   output logic                       req_full,
   input  logic                       rsp_pop,
   output logic                       rsp_empty,
   output logic [TARGET_W-1:0]        rsp_target,
   output logic signed [AMOUNT_W-1:0] rsp_amount,
   output logic                       rsp_pointer_takeover,
   input  logic                       csr_we,
   input  logic [CSR_INDEX_W-1:0]     csr_index,
   input  logic [CSR_DATA_W-1:0]      csr_wdata
);

   logic    req_accept;
   logic    op_valid;
   op_type  front_op;
   op_type  back_op;
   logic    op_empty;
   logic    out_full;
   logic    back_go;
   rsp_type back_rsp;
   rsp_type out_rsp;

   assign req_accept = req_push && !req_full;
   assign back_go    = !op_empty && !out_full;

   skc_front u_front (
      .clock     (clock),
      .reset     (reset),
      .accept    (req_accept),
      .scan_byte (req_scan_byte),
      .op_valid  (op_valid),
      .op        (front_op)
   );

   skc_queue #(
      .WIDTH ($bits(op_type)),
      .DEPTH (OP_DEPTH)
   ) u_op_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (req_accept && op_valid),
      .wr_data (front_op),
      .full    (req_full),
      .pop     (back_go),
      .rd_data (back_op),
      .empty   (op_empty)
   );

   skc_back u_back (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .op        (back_op),
      .rsp       (back_rsp)
   );

   skc_queue #(
      .WIDTH ($bits(rsp_type)),
      .DEPTH (RSP_DEPTH)
   ) u_rsp_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (back_go),
      .wr_data (back_rsp),
      .full    (out_full),
      .pop     (rsp_pop),
      .rd_data (out_rsp),
      .empty   (rsp_empty)
   );

   assign rsp_target           = out_rsp.target;
   assign rsp_amount           = out_rsp.amount;
   assign rsp_pointer_takeover = out_rsp.pointer_takeover;

endmodule

FILE: dv/testbench.sv
// self-checking testbench for scancode_to_key_event: directed table, then random scancode words
// predicts key, pointer and button words and compares them in order; depends on skc_pkg
module testbench;
   import skc_pkg::*;

   typedef struct packed {
      logic [SCAN_W-1:0] scan;
      logic              typed;
      logic              fires;
      rsp_type           word;
   } directed_row_type;

   localparam logic [AMOUNT_W-1:0] STEP_UP_AMOUNT   = AMOUNT_W'(STEP_RESET);
   localparam logic [AMOUNT_W-1:0] STEP_DOWN_AMOUNT = -STEP_UP_AMOUNT;
   localparam logic [AMOUNT_W-1:0] PRESS_AMOUNT     = AMOUNT_W'(BUTTON_RESET);
   localparam rsp_type             NO_WORD          = '0;

   localparam logic [KEY_W-1:0] PLAIN_KEYS [MAP_LEN] = '{
      8'h00, 8'h1B, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36,
      8'h37, 8'h38, 8'h39, 8'h30, 8'h2D, 8'h3D, 8'h08, 8'h09,
      8'h71, 8'h77, 8'h65, 8'h72, 8'h74, 8'h79, 8'h75, 8'h69,
      8'h6F, 8'h70, 8'h5B, 8'h5D, 8'h0A, 8'h00, 8'h61, 8'h73,
      8'h64, 8'h66, 8'h67, 8'h68, 8'h6A, 8'h6B, 8'h6C, 8'h3B,
      8'h27, 8'h60, 8'h00, 8'h5C, 8'h7A, 8'h78, 8'h63, 8'h76,
      8'h62, 8'h6E, 8'h6D, 8'h2C, 8'h2E, 8'h2F, 8'h00, 8'h00,
      8'h00, 8'h20
   };

   localparam logic [KEY_W-1:0] SHIFTED_KEYS [MAP_LEN] = '{
      8'h00, 8'h1B, 8'h21, 8'h40, 8'h23, 8'h24, 8'h25, 8'h5E,
      8'h26, 8'h2A, 8'h28, 8'h29, 8'h5F, 8'h2B, 8'h08, 8'h09,
      8'h51, 8'h57, 8'h45, 8'h52, 8'h54, 8'h59, 8'h55, 8'h49,
      8'h4F, 8'h50, 8'h7B, 8'h7D, 8'h0A, 8'h00, 8'h41, 8'h53,
      8'h44, 8'h46, 8'h47, 8'h48, 8'h4A, 8'h4B, 8'h4C, 8'h3A,
      8'h22, 8'h7E, 8'h00, 8'h7C, 8'h5A, 8'h58, 8'h43, 8'h56,
      8'h42, 8'h4E, 8'h4D, 8'h3C, 8'h3E, 8'h3F, 8'h00, 8'h00,
      8'h00, 8'h20
   };

   localparam logic [SCAN_W-1:0] EXTENDED_CODES [9] = '{
      SCAN_UP, SCAN_LEFT, SCAN_DOWN, SCAN_RIGHT, SCAN_PGUP, SCAN_PGDN, SCAN_DELETE,
      SCAN_CTRL, SCAN_CTRL_UP
   };

   localparam logic [SCAN_W-1:0] KEYPAD_AND_MODIFIER_CODES [17] = '{
      SCAN_LEFT, SCAN_RIGHT, SCAN_UP, SCAN_DOWN, SCAN_KP7, SCAN_KP7_UP, SCAN_KP9,
      SCAN_KP9_UP, SCAN_KP5, SCAN_KP5_UP, SCAN_LSHIFT, SCAN_RSHIFT, SCAN_LSHIFT_UP,
      SCAN_RSHIFT_UP, SCAN_CTRL, SCAN_CTRL_UP, SCAN_CAPS
   };

   localparam directed_row_type DIRECTED [26] = '{
      '{8'h00,          1'b1, 1'b1, '{TARGET_KEY, 35'd0, 1'b0}},
      '{8'h1C,          1'b1, 1'b1, '{TARGET_KEY, AMOUNT_W'(KEY_ENTER), 1'b0}},
      '{8'h3B,          1'b1, 1'b0, NO_WORD},
      '{8'hFF,          1'b1, 1'b0, NO_WORD},
      '{SCAN_LEFT,      1'b1, 1'b1, '{TARGET_X, STEP_DOWN_AMOUNT, 1'b1}},
      '{SCAN_RIGHT,     1'b1, 1'b1, '{TARGET_X, STEP_UP_AMOUNT, 1'b1}},
      '{SCAN_UP,        1'b1, 1'b1, '{TARGET_Y, STEP_DOWN_AMOUNT, 1'b1}},
      '{SCAN_DOWN,      1'b1, 1'b1, '{TARGET_Y, STEP_UP_AMOUNT, 1'b1}},
      '{SCAN_KP7,       1'b1, 1'b1, '{TARGET_BUTTON0, PRESS_AMOUNT, 1'b1}},
      '{SCAN_KP7_UP,    1'b1, 1'b1, '{TARGET_BUTTON0, 35'd0, 1'b1}},
      '{SCAN_KP9,       1'b1, 1'b1, '{TARGET_BUTTON1, PRESS_AMOUNT, 1'b1}},
      '{SCAN_KP9_UP,    1'b1, 1'b1, '{TARGET_BUTTON1, 35'd0, 1'b1}},
      '{SCAN_KP5,       1'b1, 1'b1, '{TARGET_BUTTON2, PRESS_AMOUNT, 1'b1}},
      '{SCAN_KP5_UP,    1'b1, 1'b1, '{TARGET_BUTTON2, 35'd0, 1'b1}},
      '{SCAN_LSHIFT,    1'b1, 1'b0, NO_WORD},
      '{SCAN_CAPS,      1'b1, 1'b0, NO_WORD},
      '{SCAN_CTRL,      1'b1, 1'b0, NO_WORD},
      '{8'h2D,          1'b0, 1'b0, NO_WORD},
      '{8'h20,          1'b0, 1'b0, NO_WORD},
      '{SCAN_PREFIX,    1'b1, 1'b0, NO_WORD},
      '{SCAN_PREFIX,    1'b1, 1'b0, NO_WORD},
      '{SCAN_LEFT,      1'b0, 1'b0, NO_WORD},
      '{SCAN_PREFIX,    1'b1, 1'b0, NO_WORD},
      '{SCAN_CTRL_UP,   1'b0, 1'b0, NO_WORD},
      '{SCAN_PREFIX,    1'b1, 1'b0, NO_WORD},
      '{SCAN_DELETE,    1'b1, 1'b1, '{TARGET_KEY, AMOUNT_W'(KEY_DELETE), 1'b0}}
   };

   logic                        clock = 1'b0;
   logic                        reset = 1'b1;
   logic                        req_push = 1'b0;
   logic [SCAN_W-1:0]           req_scan_byte = '0;
   logic                        req_full;
   logic                        rsp_pop = 1'b0;
   logic                        rsp_empty;
   logic [TARGET_W-1:0]         rsp_target;
   logic signed [AMOUNT_W-1:0]  rsp_amount;
   logic                        rsp_pointer_takeover;
   logic                        csr_we = 1'b0;
   logic [CSR_INDEX_W-1:0]      csr_index = '0;
   logic [CSR_DATA_W-1:0]       csr_wdata = '0;

   logic [STEP_W-1:0]   step_setting = STEP_RESET;
   logic [BUTTON_W-1:0] button_setting = BUTTON_RESET;
   logic                shift_held = 1'b0;
   logic                ctrl_held = 1'b0;
   logic                caps_locked = 1'b0;
   logic                prefix_pending = 1'b0;

   rsp_type expected_events[$];
   rsp_type oldest_event;
   int      items_sent = 0;
   int      error_count = 0;
   int      send_idle_pct = 0;
   int      recv_idle_pct = 0;

   scancode_to_key_event u_top (
      .clock                (clock),
      .reset                (reset),
      .req_push             (req_push),
      .req_scan_byte        (req_scan_byte),
      .req_full             (req_full),
      .rsp_pop              (rsp_pop),
      .rsp_empty            (rsp_empty),
      .rsp_target           (rsp_target),
      .rsp_amount           (rsp_amount),
      .rsp_pointer_takeover (rsp_pointer_takeover),
      .csr_we               (csr_we),
      .csr_index            (csr_index),
      .csr_wdata            (csr_wdata)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("Regression FAIL");
      $finish;
   end

   function automatic logic predict_key_event(input logic [SCAN_W-1:0] scan,
                                              output rsp_type word);
      logic [KEY_W-1:0]    ch;
      logic [AMOUNT_W-1:0] step_up;
      logic [AMOUNT_W-1:0] step_down;
      step_up   = AMOUNT_W'(step_setting);
      step_down = -step_up;
      word      = '0;
      if (scan == SCAN_PREFIX) begin
         prefix_pending = 1'b1;
         return 1'b0;
      end
      // extended codes win over the keypad cases
      if (prefix_pending) begin
         prefix_pending = 1'b0;
         word.target = TARGET_KEY;
         case (scan)
            SCAN_UP:     word.amount = AMOUNT_W'(shift_held ? KEY_UP_SHIFT : KEY_UP);
            SCAN_LEFT:   word.amount = AMOUNT_W'(shift_held ? KEY_LEFT_SHIFT :
                                       (ctrl_held ? KEY_LEFT_CTRL : KEY_LEFT));
            SCAN_DOWN:   word.amount = AMOUNT_W'(shift_held ? KEY_DOWN_SHIFT : KEY_DOWN);
            SCAN_RIGHT:  word.amount = AMOUNT_W'(shift_held ? KEY_RIGHT_SHIFT :
                                       (ctrl_held ? KEY_RIGHT_CTRL : KEY_RIGHT));
            SCAN_PGUP:   word.amount = AMOUNT_W'(KEY_PGUP);
            SCAN_PGDN:   word.amount = AMOUNT_W'(KEY_PGDN);
            SCAN_DELETE: word.amount = AMOUNT_W'(KEY_DELETE);
            SCAN_CTRL, SCAN_CTRL_UP: begin
               ctrl_held = !ctrl_held;
               return 1'b0;
            end
            default: return 1'b0;
         endcase
         return 1'b1;
      end
      word.pointer_takeover = 1'b1;
      case (scan)
         SCAN_LEFT: begin
            word.target = TARGET_X;
            word.amount = step_down;
            return 1'b1;
         end
         SCAN_RIGHT: begin
            word.target = TARGET_X;
            word.amount = step_up;
            return 1'b1;
         end
         SCAN_UP: begin
            word.target = TARGET_Y;
            word.amount = step_down;
            return 1'b1;
         end
         SCAN_DOWN: begin
            word.target = TARGET_Y;
            word.amount = step_up;
            return 1'b1;
         end
         SCAN_KP7: begin
            word.target = TARGET_BUTTON0;
            word.amount = AMOUNT_W'(button_setting);
            return 1'b1;
         end
         SCAN_KP7_UP: begin
            word.target = TARGET_BUTTON0;
            return 1'b1;
         end
         SCAN_KP9: begin
            word.target = TARGET_BUTTON1;
            word.amount = AMOUNT_W'(button_setting);
            return 1'b1;
         end
         SCAN_KP9_UP: begin
            word.target = TARGET_BUTTON1;
            return 1'b1;
         end
         SCAN_KP5: begin
            word.target = TARGET_BUTTON2;
            word.amount = AMOUNT_W'(button_setting);
            return 1'b1;
         end
         SCAN_KP5_UP: begin
            word.target = TARGET_BUTTON2;
            return 1'b1;
         end
         SCAN_LSHIFT, SCAN_RSHIFT, SCAN_LSHIFT_UP, SCAN_RSHIFT_UP: begin
            shift_held = !shift_held;
            return 1'b0;
         end
         SCAN_CTRL, SCAN_CTRL_UP: begin
            ctrl_held = !ctrl_held;
            return 1'b0;
         end
         SCAN_CAPS: begin
            caps_locked = !caps_locked;
            return 1'b0;
         end
         default: ;
      endcase
      word.pointer_takeover = 1'b0;
      if (scan >= MAP_LEN) begin
         return 1'b0;
      end
      ch = shift_held ? SHIFTED_KEYS[scan[MAP_IDX_W-1:0]] : PLAIN_KEYS[scan[MAP_IDX_W-1:0]];
      if (caps_locked) begin
         if (ch >= "a" && ch <= "z") begin
            ch = ch - CASE_OFFSET;
         end else if (ch >= "A" && ch <= "Z") begin
            ch = ch + CASE_OFFSET;
         end
      end
      if (ctrl_held) begin
         if (ch == "v" || ch == "V") begin
            ch = KEY_CTRL_V;
         end else if (ch == "x" || ch == "X") begin
            ch = KEY_CTRL_X;
         end else if (ch == "c" || ch == "C") begin
            ch = KEY_CTRL_C;
         end else if (ch == "d" || ch == "D") begin
            return 1'b0;
         end
      end
      if (ch == KEY_LINEFEED) begin
         ch = KEY_ENTER;
      end
      word.target = TARGET_KEY;
      word.amount = AMOUNT_W'(ch);
      return 1'b1;
   endfunction

   task automatic report_mismatch(input string what, input logic [AMOUNT_W-1:0] got,
                                  input logic [AMOUNT_W-1:0] want);
      $display("mismatch on %s: got %h expected %h", what, got, want);
      error_count++;
   endtask

   // returns at the falling edge after the word is taken
   task automatic send_word(input logic [SCAN_W-1:0] scan);
      while ($urandom_range(99) < send_idle_pct) begin
         req_push <= 1'b0;
         @(negedge clock);
      end
      req_push      <= 1'b1;
      req_scan_byte <= scan;
      @(posedge clock);
      while (req_full) begin
         @(posedge clock);
      end
      @(negedge clock);
   endtask

   task automatic push_scan(input logic [SCAN_W-1:0] scan);
      rsp_type word;
      send_word(scan);
      items_sent++;
      if (predict_key_event(scan, word)) begin
         expected_events.push_back(word);
      end
   endtask

   task automatic wait_until_idle();
      req_push <= 1'b0;
      while (expected_events.size() != 0) begin
         @(negedge clock);
      end
      repeat (8) @(negedge clock);
   endtask

   task automatic program_registers(input logic [STEP_W-1:0] step,
                                    input logic [BUTTON_W-1:0] button);
      csr_we    <= 1'b1;
      csr_index <= CSR_POINTER_STEP;
      csr_wdata <= CSR_DATA_W'(step);
      @(negedge clock);
      csr_index <= CSR_BUTTON_DOWN;
      csr_wdata <= CSR_DATA_W'(button);
      @(negedge clock);
      csr_we         <= 1'b0;
      step_setting   = step;
      button_setting = button;
   endtask

   always @(negedge clock) begin
      rsp_pop <= !reset && ($urandom_range(99) >= recv_idle_pct);
   end

   always @(posedge clock) begin
      if (!reset && rsp_pop && !rsp_empty) begin
         if (expected_events.size() == 0) begin
            report_mismatch("word with none expected", rsp_amount, '0);
         end else begin
            oldest_event = expected_events.pop_front();
            if (rsp_target !== oldest_event.target) begin
               report_mismatch("target", AMOUNT_W'(rsp_target),
                               AMOUNT_W'(oldest_event.target));
            end
            if (rsp_amount !== oldest_event.amount) begin
               report_mismatch("amount", rsp_amount, oldest_event.amount);
            end
            if (rsp_pointer_takeover !== oldest_event.pointer_takeover) begin
               report_mismatch("pointer_takeover", AMOUNT_W'(rsp_pointer_takeover),
                               AMOUNT_W'(oldest_event.pointer_takeover));
            end
         end
      end
   end

   initial begin : stimulus
      rsp_type           word;
      logic              fires;
      logic [SCAN_W-1:0] scan;
      int                phase;
      int                phase_goal;
      int                pick;
      repeat (11) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      send_idle_pct = 29;
      recv_idle_pct = 79;
      foreach (DIRECTED[i]) begin
         send_word(DIRECTED[i].scan);
         fires = predict_key_event(DIRECTED[i].scan, word);
         if (DIRECTED[i].typed) begin
            fires = DIRECTED[i].fires;
            word  = DIRECTED[i].word;
         end
         if (fires) begin
            expected_events.push_back(word);
         end
      end
      for (phase = 0; phase < 6; phase++) begin
         wait_until_idle();
         case (phase)
            0: program_registers('0, '0);
            1: program_registers('1, '1);
            2: program_registers($urandom, {1'($urandom_range(1)), $urandom});
            3: program_registers(STEP_W'(1), BUTTON_W'(1));
            4: program_registers($urandom, {1'($urandom_range(1)), $urandom});
            default: program_registers(STEP_RESET, BUTTON_RESET);
         endcase
         if (phase == 2) begin
            send_idle_pct = 79;
            recv_idle_pct = 29;
         end else if (phase == 4) begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         phase_goal = items_sent + 254;
         while (items_sent < phase_goal) begin
            pick = $urandom_range(99);
            if (pick < 12) begin
               push_scan(SCAN_PREFIX);
               if ($urandom_range(3) == 0) begin
                  scan = SCAN_W'($urandom);
               end else begin
                  scan = EXTENDED_CODES[4'($urandom_range(8))];
               end
            end else if (pick < 30) begin
               scan = KEYPAD_AND_MODIFIER_CODES[5'($urandom_range(16))];
            end else if (pick < 80) begin
               scan = SCAN_W'($urandom_range(MAP_LEN - 1));
            end else begin
               scan = SCAN_W'($urandom_range(255));
            end
            push_scan(scan);
         end
      end
      wait_until_idle();
      if (error_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
